### rtl/slfd_pkg.sv
// shared types, constants and the status-to-color table for the status led frame differ
// no dependencies
package slfd_pkg;

    localparam int unsigned STATUS_W   = 4;
    localparam int unsigned COLOR_W    = 2;
    localparam int unsigned SHOWN_W    = 3;
    localparam int unsigned LED_KEY_W  = 6;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned SUM_W      = 11;
    localparam int unsigned CX_W       = 8;
    localparam int unsigned CY_W       = 16;

    localparam logic OP_RECORD    = 1'b0;
    localparam logic OP_END_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LENGTHS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OFF          = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ACTIVE       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_INACTIVE     = 4'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 4'd3;
    localparam logic [STATUS_W-1:0] ST_MIXED        = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BLINK        = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SEL_ON       = 4'd6;
    localparam logic [STATUS_W-1:0] ST_SEL_OFF      = 4'd7;
    localparam logic [STATUS_W-1:0] ST_CHOOSE_AVAIL = 4'd8;
    localparam logic [STATUS_W-1:0] ST_CHOOSE_USED  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_CHOOSE_ACT   = 4'd10;

    localparam logic [COLOR_W-1:0] CLR_OFF   = 2'd0;
    localparam logic [COLOR_W-1:0] CLR_GRN   = 2'd1;
    localparam logic [COLOR_W-1:0] CLR_RED   = 2'd2;
    localparam logic [COLOR_W-1:0] CLR_AMBER = 2'd3;

    localparam logic [SHOWN_W-1:0] CLR_UNKNOWN = 3'd7;

    typedef struct packed {
        logic load;
        logic locx;
        logic locy;
        logic rec_rd;
        logic rec_wr;
        logic scan_init;
        logic scan_rd;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_end;
    } ctrl_stat_t;

    function automatic logic [COLOR_W-1:0] color_of(input logic [STATUS_W-1:0] st);
        logic [COLOR_W-1:0] c;
        unique case (st)
            ST_OFF:          c = CLR_OFF;
            ST_ACTIVE:       c = CLR_GRN;
            ST_INACTIVE:     c = CLR_RED;
            ST_UNKNOWN:      c = CLR_AMBER;
            ST_MIXED:        c = CLR_AMBER;
            ST_BLINK:        c = CLR_AMBER;
            ST_SEL_ON:       c = CLR_GRN;
            ST_SEL_OFF:      c = CLR_RED;
            ST_CHOOSE_AVAIL: c = CLR_RED;
            ST_CHOOSE_USED:  c = CLR_AMBER;
            ST_CHOOSE_ACT:   c = CLR_GRN;
            default:         c = CLR_OFF;
        endcase
        return c;
    endfunction

endpackage

### rtl/slfd_ctrl.sv
// control state machine: sequences record lookup/update and end-of-frame scan
// depends on slfd_pkg
module slfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    output logic                busy,
    output slfd_pkg::ctrl_cmd_t cmd,
    input  slfd_pkg::ctrl_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOCX,
        S_LOCY,
        S_RD,
        S_WR,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (op == slfd_pkg::OP_END_FRAME)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_LOCX;
                    end
                end
            end
            S_LOCX:
            begin
                cmd.locx   = 1'b1;
                state_next = S_LOCY;
            end
            S_LOCY:
            begin
                cmd.locy   = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rec_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.rec_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/slfd_datapath.sv
// datapath: config registers, key locator, frame status and shown color stores, scan and output
// depends on slfd_pkg
module slfd_datapath #(
    parameter int unsigned KEY_COUNT  = 64,
    parameter int unsigned COLUMN_MAX = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  slfd_pkg::ctrl_cmd_t                   cmd,
    output slfd_pkg::ctrl_stat_t                  stat,
    input  logic                                  cfg_write,
    input  logic [slfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  musical,
    input  logic signed [slfd_pkg::CX_W-1:0]      coord_x,
    input  logic signed [slfd_pkg::CY_W-1:0]      coord_y,
    input  logic                                  x_from_end,
    input  logic                                  y_from_end,
    input  logic [slfd_pkg::STATUS_W-1:0]         status_code,
    output logic                                  led_strobe,
    output logic [slfd_pkg::LED_KEY_W-1:0]        led_key,
    output logic [slfd_pkg::COLOR_W-1:0]          led_color,
    output logic                                  last_change
);

    localparam int unsigned AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int unsigned CW   = $clog2(KEY_COUNT + 1);
    localparam int unsigned CIW  = $clog2(COLUMN_MAX + 1);
    localparam int unsigned COLW = (COLUMN_MAX > 1) ? $clog2(COLUMN_MAX) : 1;
    localparam int unsigned XW   = 10;
    localparam int unsigned YW   = 18;

    // config
    logic [slfd_pkg::COUNT_W-1:0]    column_count_reg;
    logic [slfd_pkg::CFG_DATA_W-1:0] column_lengths_reg;

    // derived column geometry
    logic [slfd_pkg::LEN_W-1:0] col_len   [COLUMN_MAX];
    logic [slfd_pkg::SUM_W-1:0] prefix_next [COLUMN_MAX+1];
    logic [slfd_pkg::SUM_W-1:0] prefix_reg  [COLUMN_MAX+1];
    logic [CIW-1:0]             cols_next;
    logic [CIW-1:0]             cols_reg;
    logic [slfd_pkg::SUM_W-1:0] total_reg;

    // captured item
    logic                             musical_reg;
    logic signed [slfd_pkg::CX_W-1:0] coord_x_reg;
    logic signed [slfd_pkg::CY_W-1:0] coord_y_reg;
    logic                             x_from_end_reg;
    logic                             y_from_end_reg;
    logic [slfd_pkg::STATUS_W-1:0]    status_reg;

    // locator
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] colsx;
    logic signed [XW-1:0] xa;
    logic signed [XW-1:0] xm1;
    logic                 x_ok;
    logic                 x_ok_reg;
    logic [COLW-1:0]      col_reg;
    logic signed [YW-1:0] lim;
    logic signed [YW-1:0] ys;
    logic signed [YW-1:0] ya;
    logic signed [YW-1:0] base;
    logic signed [YW-1:0] k;
    logic                 hit;
    logic                 hit_reg;
    logic [AW-1:0]        key_reg;

    // stores
    logic [slfd_pkg::STATUS_W-1:0] fs_mem [KEY_COUNT];
    logic [slfd_pkg::SHOWN_W-1:0]  sc_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0]          fs_vld_reg;
    logic [KEY_COUNT-1:0]          sc_vld_reg;
    logic [AW-1:0]                 rd_addr;
    logic                          rd_en;
    logic [slfd_pkg::STATUS_W-1:0] fs_rd_reg;
    logic                          fs_vrd_reg;
    logic [slfd_pkg::SHOWN_W-1:0]  sc_rd_reg;
    logic                          sc_vrd_reg;
    logic [slfd_pkg::STATUS_W-1:0] fs_cur;
    logic                          fs_we;
    logic [slfd_pkg::STATUS_W-1:0] fs_wdata;
    logic                          sc_we;
    logic [slfd_pkg::SHOWN_W-1:0]  sc_cur;
    logic [slfd_pkg::COLOR_W-1:0]  new_color;

    // scan
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_scan;
    logic          scan_end;
    logic          scan_vld_reg;
    logic [AW-1:0] scan_addr_reg;
    logic          change;

    // pending and output beat
    logic                         pend_vld_reg;
    logic [AW-1:0]                pend_key_reg;
    logic [slfd_pkg::COLOR_W-1:0] pend_color_reg;
    logic                         out_fire;
    logic                         led_strobe_reg;
    logic [AW-1:0]                led_key_reg;
    logic [slfd_pkg::COLOR_W-1:0] led_color_reg;
    logic                         last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= slfd_pkg::COUNT_W'(1);
            column_lengths_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                slfd_pkg::CFG_COLUMN_COUNT:
                    column_count_reg <= cfg_data[slfd_pkg::COUNT_W-1:0];
                slfd_pkg::CFG_COLUMN_LENGTHS:
                    column_lengths_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prefix_next[0] = '0;
        for (int i = 0; i < COLUMN_MAX; i++)
        begin
            col_len[i]       = column_lengths_reg[slfd_pkg::LEN_W*i +: slfd_pkg::LEN_W];
            prefix_next[i+1] = prefix_next[i] + slfd_pkg::SUM_W'(col_len[i]);
        end
        cols_next = (column_count_reg > slfd_pkg::COUNT_W'(COLUMN_MAX))
                  ? CIW'(COLUMN_MAX) : CIW'(column_count_reg);
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        cols_reg   <= cols_next;
        total_reg  <= prefix_next[cols_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            musical_reg    <= musical;
            coord_x_reg    <= coord_x;
            coord_y_reg    <= coord_y;
            x_from_end_reg <= x_from_end;
            y_from_end_reg <= y_from_end;
            status_reg     <= status_code;
        end
    end

    // column stage
    always_comb
    begin
        xs    = XW'(coord_x_reg);
        colsx = $signed(XW'(cols_reg));
        xa    = x_from_end_reg ? (colsx + XW'(1) - xs) : xs;
        xm1   = xa - XW'(1);
        x_ok  = musical_reg ? (xs == XW'(1))
                            : ((xa >= $signed(XW'(1))) && (xa <= colsx));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.locx)
        begin
            x_ok_reg <= x_ok;
            col_reg  <= xm1[COLW-1:0];
        end
    end

    // row / key stage
    always_comb
    begin
        lim  = musical_reg ? $signed(YW'(total_reg)) : $signed(YW'(col_len[col_reg]));
        ys   = YW'(coord_y_reg);
        ya   = y_from_end_reg ? (lim + YW'(1) - ys) : ys;
        base = musical_reg ? '0 : $signed(YW'(prefix_reg[CIW'(col_reg)]));
        k    = base + ya - YW'(1);
        hit  = x_ok_reg && (ya >= $signed(YW'(1))) && (ya <= lim)
            && (k < $signed(YW'(KEY_COUNT))) && (status_reg != slfd_pkg::ST_OFF);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.locy)
        begin
            key_reg <= k[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.locy)
        begin
            hit_reg <= hit;
        end
    end

    // scan control
    always_comb
    begin
        n_scan   = (total_reg >= slfd_pkg::SUM_W'(KEY_COUNT)) ? CW'(KEY_COUNT)
                                                              : CW'(total_reg);
        scan_end = (cnt_reg >= n_scan);
        rd_en    = cmd.rec_rd || (cmd.scan_rd && !scan_end);
        rd_addr  = cmd.scan_rd ? cnt_reg[AW-1:0] : key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_rd && !scan_end;
            if (cmd.scan_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_rd && !scan_end)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= cnt_reg[AW-1:0];
    end

    // record merge and color compare
    always_comb
    begin
        fs_cur    = fs_vrd_reg ? fs_rd_reg : slfd_pkg::ST_OFF;
        fs_we     = cmd.rec_wr && hit_reg && (fs_cur != status_reg);
        fs_wdata  = (fs_cur != slfd_pkg::ST_OFF) ? slfd_pkg::ST_MIXED : status_reg;
        sc_cur    = sc_vrd_reg ? sc_rd_reg : slfd_pkg::CLR_UNKNOWN;
        new_color = slfd_pkg::color_of(fs_cur);
        change    = scan_vld_reg && ({1'b0, new_color} != sc_cur);
        sc_we     = change;
        out_fire  = pend_vld_reg && (change || cmd.flush);
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            fs_mem[key_reg] <= fs_wdata;
        end
        if (sc_we)
        begin
            sc_mem[scan_addr_reg] <= {1'b0, new_color};
        end
        if (rd_en)
        begin
            fs_rd_reg  <= fs_mem[rd_addr];
            fs_vrd_reg <= fs_vld_reg[rd_addr];
            sc_rd_reg  <= sc_mem[rd_addr];
            sc_vrd_reg <= sc_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_vld_reg <= '0;
            sc_vld_reg <= '0;
        end
        else
        begin
            if (cmd.flush)
            begin
                fs_vld_reg <= '0;
            end
            else if (fs_we)
            begin
                fs_vld_reg[key_reg] <= 1'b1;
            end
            if (sc_we)
            begin
                sc_vld_reg[scan_addr_reg] <= 1'b1;
            end
        end
    end

    // one changed key held back so the final one can be marked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg   <= 1'b0;
            led_strobe_reg <= 1'b0;
        end
        else
        begin
            led_strobe_reg <= out_fire;
            if (cmd.scan_init || cmd.flush)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (change)
            begin
                pend_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (change)
        begin
            pend_key_reg   <= scan_addr_reg;
            pend_color_reg <= new_color;
        end
        if (out_fire)
        begin
            led_key_reg   <= pend_key_reg;
            led_color_reg <= pend_color_reg;
            last_reg      <= cmd.flush;
        end
    end

    assign stat.scan_end = scan_end;
    assign led_strobe    = led_strobe_reg;
    assign led_key       = slfd_pkg::LED_KEY_W'(led_key_reg);
    assign led_color     = led_color_reg;
    assign last_change   = last_reg;

endmodule

### rtl/status_led_frame_diff_core.sv
// top level of the status led frame differ: controller plus datapath
// depends on slfd_pkg, slfd_ctrl, slfd_datapath
//
// channel   | ports                                              | beat taken when
// ----------+----------------------------------------------------+------------------
// item in   | op musical coord_x coord_y x_from_end y_from_end   | start && !busy
//           | status_code                                        |
// result    | led_key led_color last_change                      | led_strobe
// config    | cfg_index cfg_data                                 | cfg_write
//
// a status record occupies the block from accept to the next accept:
// column stage, row/key stage, store read, store write
// end of frame scans n = min(keys, KEY_COUNT) keys, one store read per key through the single
// read port of each store, then flushes the held beat
// results come out during the scan with a one-cycle led_strobe each; the final one, with last_change, follows the flush
// reset clears control and valid bits and sets config to one column of zero length; no clearing pass is needed
// the receiver cannot stall: results are not held back
module status_led_frame_diff_core #(
    parameter int unsigned KEY_COUNT  = 64,
    parameter int unsigned COLUMN_MAX = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic                                  musical,
    input  logic signed [slfd_pkg::CX_W-1:0]      coord_x,
    input  logic signed [slfd_pkg::CY_W-1:0]      coord_y,
    input  logic                                  x_from_end,
    input  logic                                  y_from_end,
    input  logic [slfd_pkg::STATUS_W-1:0]         status_code,
    output logic                                  led_strobe,
    output logic [slfd_pkg::LED_KEY_W-1:0]        led_key,
    output logic [slfd_pkg::COLOR_W-1:0]          led_color,
    output logic                                  last_change,
    input  logic                                  cfg_write,
    input  logic [slfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    slfd_pkg::ctrl_cmd_t  cmd;
    slfd_pkg::ctrl_stat_t stat;

    slfd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    slfd_datapath #(
        .KEY_COUNT  (KEY_COUNT),
        .COLUMN_MAX (COLUMN_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .musical     (musical),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .x_from_end  (x_from_end),
        .y_from_end  (y_from_end),
        .status_code (status_code),
        .led_strobe  (led_strobe),
        .led_key     (led_key),
        .led_color   (led_color),
        .last_change (last_change)
    );

endmodule

### test/slfd_change_board.sv
`timescale 1ns / 1ps
// scoreboard for the status led frame differ: predicts which keys change color at end of frame
// depends on slfd_pkg
package slfd_tb_pkg;

    localparam int KEYS = 64;
    localparam int GRID_COLUMNS_MAX = 8;

    typedef struct {
        logic [slfd_pkg::LED_KEY_W-1:0] key;
        logic [slfd_pkg::COLOR_W-1:0]   color;
        logic                           last;
    } led_change_t;

    class led_change_board;
        logic [slfd_pkg::COUNT_W-1:0]    column_count;
        logic [slfd_pkg::CFG_DATA_W-1:0] column_lengths;
        logic [slfd_pkg::STATUS_W-1:0]   frame_status [KEYS];
        logic [slfd_pkg::SHOWN_W-1:0]    shown_color [KEYS];
        led_change_t                     pending_changes [$];
        int                              errors;

        function new();
            errors = 0;
            column_count = 1;
            column_lengths = '0;
            foreach (frame_status[i]) frame_status[i] = slfd_pkg::ST_OFF;
            foreach (shown_color[i]) shown_color[i] = slfd_pkg::CLR_UNKNOWN;
        endfunction

        function void write_reg(logic [slfd_pkg::CFG_IDX_W-1:0] idx,
                                logic [slfd_pkg::CFG_DATA_W-1:0] data);
            if (idx == slfd_pkg::CFG_COLUMN_COUNT)
                column_count = data[slfd_pkg::COUNT_W-1:0];
            else
                column_lengths = data;
        endfunction

        function int grid_columns();
            return (column_count > GRID_COLUMNS_MAX) ? GRID_COLUMNS_MAX : int'(column_count);
        endfunction

        function int column_keys(int c);
            return int'(column_lengths[8*c +: 8]);
        endfunction

        function int grid_keys();
            int n;
            n = 0;
            for (int i = 0; i < grid_columns(); i++) n += column_keys(i);
            return n;
        endfunction

        function logic [slfd_pkg::COLOR_W-1:0] status_color(logic [slfd_pkg::STATUS_W-1:0] st);
            unique case (st)
                slfd_pkg::ST_ACTIVE, slfd_pkg::ST_SEL_ON, slfd_pkg::ST_CHOOSE_ACT:
                    return slfd_pkg::CLR_GRN;
                slfd_pkg::ST_INACTIVE, slfd_pkg::ST_SEL_OFF, slfd_pkg::ST_CHOOSE_AVAIL:
                    return slfd_pkg::CLR_RED;
                slfd_pkg::ST_UNKNOWN, slfd_pkg::ST_MIXED, slfd_pkg::ST_BLINK,
                slfd_pkg::ST_CHOOSE_USED:
                    return slfd_pkg::CLR_AMBER;
                default:
                    return slfd_pkg::CLR_OFF;
            endcase
        endfunction

        // key index of a record, -1 when dropped
        function int locate_key(logic musical, int x, int y, logic xe, logic ye);
            int n;
            int cols;
            int len;
            int offset;
            int k;
            if (musical)
            begin
                n = grid_keys();
                if (x != 1) return -1;
                if (y < 1 || y > n) return -1;
                k = ye ? (n - y) : (y - 1);
            end
            else
            begin
                cols = grid_columns();
                if (xe) x = cols - x + 1;
                if (x < 1 || x > cols) return -1;
                len = column_keys(x - 1);
                if (ye) y = len - y + 1;
                if (y < 1 || y > len) return -1;
                offset = 0;
                for (int i = 0; i < x - 1; i++) offset += column_keys(i);
                k = offset + y - 1;
            end
            if (k < 0 || k >= KEYS) return -1;
            return k;
        endfunction

        function void note_item(logic op, logic musical, logic signed [slfd_pkg::CX_W-1:0] x,
                                logic signed [slfd_pkg::CY_W-1:0] y, logic xe, logic ye,
                                logic [slfd_pkg::STATUS_W-1:0] st);
            int k;
            int n;
            logic [slfd_pkg::COLOR_W-1:0] c;
            led_change_t frame_changes [$];
            led_change_t beat;
            if (op == slfd_pkg::OP_RECORD)
            begin
                if (st == slfd_pkg::ST_OFF) return;
                k = locate_key(musical, int'(x), int'(y), xe, ye);
                if (k >= 0 && frame_status[k] != st)
                    frame_status[k] = (frame_status[k] != slfd_pkg::ST_OFF)
                                    ? slfd_pkg::ST_MIXED : st;
            end
            else
            begin
                n = grid_keys();
                if (n > KEYS) n = KEYS;
                for (int i = 0; i < n; i++)
                begin
                    c = status_color(frame_status[i]);
                    if ({1'b0, c} != shown_color[i])
                    begin
                        shown_color[i] = {1'b0, c};
                        beat.key = slfd_pkg::LED_KEY_W'(i);
                        beat.color = c;
                        beat.last = 1'b0;
                        frame_changes.push_back(beat);
                    end
                end
                if (frame_changes.size() > 0)
                    frame_changes[frame_changes.size() - 1].last = 1'b1;
                foreach (frame_changes[i]) pending_changes.push_back(frame_changes[i]);
                foreach (frame_status[i]) frame_status[i] = slfd_pkg::ST_OFF;
            end
        endfunction

        function void check_led(logic [slfd_pkg::LED_KEY_W-1:0] key,
                                logic [slfd_pkg::COLOR_W-1:0] color, logic last);
            led_change_t want;
            if (pending_changes.size() == 0)
            begin
                $display("%0t: led beat with nothing expected: key %0d color %0d last %0d",
                         $time, key, color, last);
                errors++;
                return;
            end
            want = pending_changes.pop_front();
            if (key !== want.key || color !== want.color || last !== want.last)
            begin
                $display("%0t: led beat exp/got: key %0d/%0d color %0d/%0d last %0d/%0d",
                         $time, want.key, key, want.color, color, want.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_changes.size();
        endfunction
    endclass

endpackage

### test/status_led_frame_diff_core_tb.sv
`timescale 1ns / 1ps
// testbench for status_led_frame_diff_core: directed and random record/frame traffic
// depends on slfd_pkg, slfd_tb_pkg (test/slfd_change_board.sv) and the rtl
module status_led_frame_diff_core_tb;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  start = 1'b0;
    logic                                  busy;
    logic                                  op = 1'b0;
    logic                                  musical = 1'b0;
    logic signed [slfd_pkg::CX_W-1:0]      coord_x = '0;
    logic signed [slfd_pkg::CY_W-1:0]      coord_y = '0;
    logic                                  x_from_end = 1'b0;
    logic                                  y_from_end = 1'b0;
    logic [slfd_pkg::STATUS_W-1:0]         status_code = '0;
    logic                                  led_strobe;
    logic [slfd_pkg::LED_KEY_W-1:0]        led_key;
    logic [slfd_pkg::COLOR_W-1:0]          led_color;
    logic                                  last_change;
    logic                                  cfg_write = 1'b0;
    logic [slfd_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [slfd_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    slfd_tb_pkg::led_change_board board = new();

    int                              grid_cols = 1;
    logic [slfd_pkg::CFG_DATA_W-1:0] grid_lens = '0;
    int                              burst_left = 0;

    status_led_frame_diff_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .musical(musical),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .x_from_end(x_from_end),
        .y_from_end(y_from_end),
        .status_code(status_code),
        .led_strobe(led_strobe),
        .led_key(led_key),
        .led_color(led_color),
        .last_change(last_change),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && led_strobe === 1'b1)
            board.check_led(led_key, led_color, last_change);
    end

    task automatic send(logic o, logic m, logic signed [slfd_pkg::CX_W-1:0] x,
                        logic signed [slfd_pkg::CY_W-1:0] y, logic xe, logic ye,
                        logic [slfd_pkg::STATUS_W-1:0] st);
        @(negedge clk);
        start <= 1'b1;
        op <= o;
        musical <= m;
        coord_x <= x;
        coord_y <= y;
        x_from_end <= xe;
        y_from_end <= ye;
        status_code <= st;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(o, m, x, y, xe, ye, st);
    endtask

    // sender bursts and gaps
    task automatic pace(bit idle_on);
        int gap;
        if (!idle_on) return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 7);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 10);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0 || busy) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [slfd_pkg::CFG_IDX_W-1:0] idx,
                             logic [slfd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(logic [slfd_pkg::CFG_DATA_W-1:0] count_data,
                             logic [slfd_pkg::CFG_DATA_W-1:0] lens);
        settle();
        write_reg(slfd_pkg::CFG_COLUMN_COUNT, count_data);
        write_reg(slfd_pkg::CFG_COLUMN_LENGTHS, lens);
        grid_cols = (count_data[slfd_pkg::COUNT_W-1:0] > slfd_tb_pkg::GRID_COLUMNS_MAX)
                  ? slfd_tb_pkg::GRID_COLUMNS_MAX
                  : int'(count_data[slfd_pkg::COUNT_W-1:0]);
        grid_lens = lens;
    endtask

    task automatic random_item();
        int r;
        int n;
        int c;
        int len;
        int row;
        logic xe;
        logic ye;
        logic [slfd_pkg::STATUS_W-1:0] st;
        r = $urandom_range(99);
        xe = 1'($urandom_range(1));
        ye = 1'($urandom_range(1));
        st = ($urandom_range(99) < 85) ? slfd_pkg::STATUS_W'($urandom_range(1, 10))
                                       : slfd_pkg::STATUS_W'($urandom_range(15));
        if (r < 12)
        begin
            send(slfd_pkg::OP_END_FRAME, 1'($urandom_range(1)),
                 slfd_pkg::CX_W'($urandom_range(255)), slfd_pkg::CY_W'($urandom_range(65535)),
                 xe, ye, slfd_pkg::STATUS_W'($urandom_range(15)));
        end
        else if (r < 22)
        begin
            send(slfd_pkg::OP_RECORD, 1'($urandom_range(1)),
                 slfd_pkg::CX_W'($urandom_range(255)), slfd_pkg::CY_W'($urandom_range(65535)),
                 xe, ye, slfd_pkg::STATUS_W'($urandom_range(15)));
        end
        else if (r < 42)
        begin
            n = 0;
            for (int i = 0; i < grid_cols; i++) n += int'(grid_lens[8*i +: 8]);
            row = (n > 0) ? $urandom_range(1, n) : 1;
            if (n > 72 && $urandom_range(1)) row = $urandom_range(1, 72);
            if ($urandom_range(9) == 0) row = $urandom_range(1) ? n + 1 : 0;
            send(slfd_pkg::OP_RECORD, 1'b1,
                 ($urandom_range(9) == 0) ? slfd_pkg::CX_W'($urandom_range(255)) : 8'sd1,
                 slfd_pkg::CY_W'(row), xe, ye, st);
        end
        else
        begin
            c = (grid_cols > 0) ? $urandom_range(1, grid_cols) : $urandom_range(1, 3);
            if ($urandom_range(12) == 0) c = $urandom_range(1) ? grid_cols + 1 : 0;
            len = (c >= 1 && c <= slfd_tb_pkg::GRID_COLUMNS_MAX)
                ? int'(grid_lens[8*(c-1) +: 8]) : 0;
            row = (len > 0) ? $urandom_range(1, len) : 1;
            if (len > 16 && $urandom_range(1)) row = $urandom_range(1, 16);
            if ($urandom_range(12) == 0) row = $urandom_range(1) ? len + 1 : 0;
            send(slfd_pkg::OP_RECORD, 1'b0, slfd_pkg::CX_W'(xe ? grid_cols - c + 1 : c),
                 slfd_pkg::CY_W'(ye ? len - row + 1 : row), xe, ye, st);
        end
    endtask

    task automatic run_random(int count, bit idle_on);
        repeat (count)
        begin
            random_item();
            pace(idle_on);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: no keys, nothing comes out
        send(slfd_pkg::OP_RECORD, 1'b1, 8'sd1, 16'sd1, 1'b0, 1'b0, slfd_pkg::ST_ACTIVE);
        send(slfd_pkg::OP_END_FRAME, 1'b0, 8'sd0, 16'sd0, 1'b0, 1'b0, slfd_pkg::ST_OFF);

        configure(64'd8, 64'h0808_0808_0808_0808);
        send(slfd_pkg::OP_RECORD, 1'b0, 8'sd1, 16'sd1, 1'b0, 1'b0, slfd_pkg::ST_ACTIVE);
        pace(1'b1);
        send(slfd_pkg::OP_RECORD, 1'b0, 8'sd1, 16'sd1, 1'b0, 1'b0, slfd_pkg::ST_INACTIVE);
        send(slfd_pkg::OP_RECORD, 1'b1, 8'sd1, 16'sd1, 1'b0, 1'b1, slfd_pkg::ST_CHOOSE_ACT);
        send(slfd_pkg::OP_RECORD, 1'b1, 8'sd1, 16'sd0, 1'b0, 1'b1, slfd_pkg::ST_ACTIVE);
        send(slfd_pkg::OP_RECORD, 1'b1, 8'sd2, 16'sd5, 1'b0, 1'b0, slfd_pkg::ST_ACTIVE);
        send(slfd_pkg::OP_RECORD, 1'b0, 8'sd1, 16'sd1, 1'b1, 1'b1, slfd_pkg::ST_SEL_OFF);
        send(slfd_pkg::OP_RECORD, 1'b0, 8'sd127, 16'sd32767, 1'b0, 1'b0, slfd_pkg::ST_ACTIVE);
        send(slfd_pkg::OP_RECORD, 1'b0, -8'sd128, -16'sd32768, 1'b1, 1'b1,
             slfd_pkg::ST_ACTIVE);
        for (int s = 0; s < 16; s++)
        begin
            send(slfd_pkg::OP_RECORD, 1'b1, 8'sd1, slfd_pkg::CY_W'(17 + s), 1'b0, 1'b0,
                 slfd_pkg::STATUS_W'(s));
            pace(1'b1);
        end
        send(slfd_pkg::OP_END_FRAME, 1'b0, 8'sd0, 16'sd0, 1'b0, 1'b0, slfd_pkg::ST_OFF);
        send(slfd_pkg::OP_END_FRAME, 1'b1, -8'sd1, -16'sd1, 1'b1, 1'b1,
             slfd_pkg::STATUS_W'(15));
        send(slfd_pkg::OP_END_FRAME, 1'b0, 8'sd0, 16'sd0, 1'b0, 1'b0, slfd_pkg::ST_OFF);

        run_random(80, 1'b1);
        configure({$urandom, 28'h0, 4'd3},
                  {40'h0, 8'($urandom_range(6)), 8'($urandom_range(6)),
                   8'($urandom_range(6))});
        run_random(80, 1'b0);
        configure({$urandom, 28'h0, 4'hF}, {64{1'b1}});
        run_random(60, 1'b1);
        configure(64'd1, 64'h40);
        run_random(80, 1'b1);
        configure(64'd0, {$urandom, $urandom});
        run_random(30, 1'b1);
        configure(64'd9, {8'($urandom_range(12)), 8'($urandom_range(12)),
                          8'($urandom_range(12)), 8'($urandom_range(12)),
                          8'($urandom_range(12)), 8'($urandom_range(12)),
                          8'($urandom_range(12)), 8'($urandom_range(12))});
        run_random(80, 1'b1);
        configure(64'd5, {24'h0, 8'd20, 8'd0, 8'($urandom_range(20)), 8'd20,
                          8'($urandom_range(3))});
        run_random(80, 1'b1);

        settle();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/slfd_pkg.sv
rtl/slfd_ctrl.sv
rtl/slfd_datapath.sv
rtl/status_led_frame_diff_core.sv
test/slfd_change_board.sv
test/status_led_frame_diff_core_tb.sv
